>>> design/lsd_pkg.sv
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int STACK_DEPTH_DEFAULT = 32;
    localparam int DATA_W              = 32;
    localparam int CMD_W               = 3;
    localparam int STATUS_W            = 2;
    localparam int DEPTH_W             = 6;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_LIST
    } state_t;

    typedef struct packed {
        logic        [CMD_W-1:0]  command;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   data;
        logic        [STATUS_W-1:0] status;
        logic        [DEPTH_W-1:0]  depth;
        logic                       last;
    } out_item_t;

endpackage

>>> design/lifo_stack_with_dump_top.sv
`timescale 1ns / 1ps

// Channel   Ports                        Direction  Moves
// input     s_valid, s_ready, s_item     in         one command item
// result    m_valid, m_ready, m_item     out        one result item
//
// Push, and any command on an empty stack, give their result without a memory read; invalid codes are dropped.
// Pop and peek make one synchronous read of the stack memory, then give the result.
// Dump and clear give every word from the top down: one read per word through the single read port.
// Reset (aresetn low, synchronous) empties the stack; the memory itself is not cleared.
// A stalled result holds the read data, so m_ready low simply pauses the run.

module lifo_stack_with_dump_top #(
    parameter int STACK_DEPTH = lsd_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lsd_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output lsd_pkg::out_item_t m_item
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [lsd_pkg::DATA_W-1:0] mem [STACK_DEPTH];

    lsd_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [lsd_pkg::DEPTH_W-1:0]     depth_hold_reg, depth_hold_next;
    logic signed [lsd_pkg::DATA_W-1:0] rd_data_reg;

    logic                            m_valid_reg;
    lsd_pkg::out_item_t              m_item_reg;

    logic                            out_free;
    logic                            accept;
    logic                            cmd_ok;
    logic                            empty;
    logic                            full;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic                            emit;
    lsd_pkg::out_item_t              emit_item;
    logic [CW-1:0]                   count_dec;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == lsd_pkg::ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign cmd_ok    = (s_item.command <= lsd_pkg::CMD_CLEAR);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign count_dec = count_reg - CW'(1);
    assign wr_addr   = count_reg[AW-1:0];

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsd_pkg::ST_IDLE: begin
                if (accept && !empty && (s_item.command != lsd_pkg::CMD_PUSH) && cmd_ok) begin
                    if (s_item.command == lsd_pkg::CMD_POP ||
                        s_item.command == lsd_pkg::CMD_PEEK) begin
                        state_next = lsd_pkg::ST_SINGLE;
                    end else begin
                        state_next = lsd_pkg::ST_LIST;
                    end
                end
            end
            lsd_pkg::ST_SINGLE: begin
                if (out_free) begin
                    state_next = lsd_pkg::ST_IDLE;
                end
            end
            lsd_pkg::ST_LIST: begin
                if (out_free && idx_reg == '0) begin
                    state_next = lsd_pkg::ST_IDLE;
                end
            end
            default: state_next = lsd_pkg::ST_IDLE;
        endcase
    end

    // datapath control and result
    always_comb begin
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = count_dec[AW-1:0];
        emit            = 1'b0;
        emit_item       = '0;
        count_next      = count_reg;
        idx_next        = idx_reg;
        depth_hold_next = depth_hold_reg;
        unique case (state_reg)
            lsd_pkg::ST_IDLE: begin
                if (accept && cmd_ok) begin
                    if (s_item.command == lsd_pkg::CMD_PUSH) begin
                        emit             = 1'b1;
                        emit_item.data   = s_item.value;
                        emit_item.last   = 1'b1;
                        if (full) begin
                            emit_item.status = lsd_pkg::STATUS_FULL;
                            emit_item.depth  = lsd_pkg::DEPTH_W'(count_reg);
                        end else begin
                            wr_en            = 1'b1;
                            count_next       = count_reg + CW'(1);
                            emit_item.status = lsd_pkg::STATUS_OK;
                            emit_item.depth  = lsd_pkg::DEPTH_W'(count_reg + CW'(1));
                        end
                    end else if (empty) begin
                        emit             = 1'b1;
                        emit_item.status = lsd_pkg::STATUS_EMPTY;
                        emit_item.last   = 1'b1;
                    end else begin
                        // fetch the top word; the result follows from the read register
                        rd_en    = 1'b1;
                        idx_next = count_dec[AW-1:0];
                        unique case (s_item.command)
                            lsd_pkg::CMD_POP: begin
                                count_next      = count_dec;
                                depth_hold_next = lsd_pkg::DEPTH_W'(count_dec);
                            end
                            lsd_pkg::CMD_CLEAR: begin
                                count_next      = '0;
                                depth_hold_next = '0;
                            end
                            default: begin
                                depth_hold_next = lsd_pkg::DEPTH_W'(count_reg);
                            end
                        endcase
                    end
                end
            end
            lsd_pkg::ST_SINGLE: begin
                if (out_free) begin
                    emit             = 1'b1;
                    emit_item.data   = rd_data_reg;
                    emit_item.status = lsd_pkg::STATUS_OK;
                    emit_item.depth  = depth_hold_reg;
                    emit_item.last   = 1'b1;
                end
            end
            lsd_pkg::ST_LIST: begin
                if (out_free) begin
                    emit             = 1'b1;
                    emit_item.data   = rd_data_reg;
                    emit_item.status = lsd_pkg::STATUS_OK;
                    emit_item.depth  = depth_hold_reg;
                    emit_item.last   = (idx_reg == '0);
                    if (idx_reg != '0) begin
                        // advance to the next word down
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_item.value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsd_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        depth_hold_reg <= depth_hold_next;
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

endmodule
